@@ rtl/wlfs_pkg.sv @@
package wlfs_pkg;

    // Fixed field and storage sizes
    localparam int COORD_BITS      = 24;
    localparam int MAP_CELLS       = 1048576;
    localparam int MAP_AW          = $clog2(MAP_CELLS);
    localparam int MAX_HALF_WINDOW = 64;

    // Exact fit arithmetic: numerators stay below 2**129 in magnitude
    localparam int WIDE_W = 132;
    // Point differences and their sums
    localparam int DIFF_W = COORD_BITS + 2;
    // Quotient bits kept by the divider (enough to detect saturation)
    localparam int QBITS  = COORD_BITS + 2;

    typedef logic signed [WIDE_W-1:0]     t_wide;
    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord     x;
        t_coord     y;
        logic [1:0] src;
        logic       last;
    } t_res;

    // Result source codes
    localparam logic [1:0] SRC_ECHO  = 2'd0;
    localparam logic [1:0] SRC_DEGEN = 2'd1;
    localparam logic [1:0] SRC_OBST  = 2'd2;
    localparam logic [1:0] SRC_PROJ  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_MAP_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_MAP_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_CELL_SIZE  = 3'd2;
    localparam logic [2:0] CFG_HALF_X     = 3'd3;
    localparam logic [2:0] CFG_HALF_Y     = 3'd4;
    localparam logic [2:0] CFG_MAP_VALID  = 3'd5;

    // Occupancy threshold on the signed cell value
    localparam logic signed [7:0] OCC_LIMIT = 8'sd100;

endpackage

@@ rtl/waypoint_line_fit_smoother.sv @@
// Map write: updates the grid memory, no result.
// Endpoint echo: the point itself is returned as the result.
// Smoothed point: 14 multiplies, then 2 to 4 divisions, then, with the map check on,
// a footprint scan of up to 4*hx*hy cells through the grid memory's read port.
// Reset is synchronous, active low; the grid memory is not cleared and holds garbage.
module waypoint_line_fit_smoother (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // map_index[19:0], map_value[27:20],
                                        // point_x_mm[51:28], point_y_mm[75:52], pad
    input  logic        s_axis_tuser,   // mode
    input  logic        s_axis_tlast,   // last_point
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_x_mm[23:0], out_y_mm[47:24]
    output logic [1:0]  m_axis_tuser,   // point_source
    output logic        m_axis_tlast,   // last_result
    // configuration
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data
);
    import wlfs_pkg::*;

    localparam int SCAN_W = COORD_BITS + 2;
    localparam int HW_W   = $clog2(MAX_HALF_WINDOW + 1);
    localparam int OFS_W  = HW_W + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [3:0] OP_U0U0 = 4'd0;
    localparam logic [3:0] OP_U2U2 = 4'd1;
    localparam logic [3:0] OP_DUDU = 4'd2;
    localparam logic [3:0] OP_U0V0 = 4'd3;
    localparam logic [3:0] OP_U2V2 = 4'd4;
    localparam logic [3:0] OP_DUDV = 4'd5;
    localparam logic [3:0] OP_DVS  = 4'd6;
    localparam logic [3:0] OP_NUS  = 4'd7;
    localparam logic [3:0] OP_NN   = 4'd8;
    localparam logic [3:0] OP_DD   = 4'd9;
    localparam logic [3:0] OP_QMX  = 4'd10;
    localparam logic [3:0] OP_NK   = 4'd11;
    localparam logic [3:0] OP_QMY  = 4'd12;
    localparam logic [3:0] OP_DK   = 4'd13;

    localparam logic [1:0] DV_PX = 2'd0;
    localparam logic [1:0] DV_PY = 2'd1;
    localparam logic [1:0] DV_CX = 2'd2;
    localparam logic [1:0] DV_CY = 2'd3;

    localparam logic [QBITS-1:0] POS_CAP = QBITS'((1 << (COORD_BITS - 1)) - 1);
    localparam logic [QBITS-1:0] NEG_CAP = QBITS'(1 << (COORD_BITS - 1));
    localparam logic [4:0]       BIT_TOP = 5'(QBITS - 1);

    // configuration
    logic [10:0] r_map_w;
    logic [10:0] r_map_h;
    logic [9:0]  r_cell;
    logic [6:0]  r_hwx;
    logic [6:0]  r_hwy;
    logic        r_map_valid;

    // control
    logic [2:0] r_state;
    logic [1:0] r_seen;
    logic [3:0] r_op;
    logic       r_mul_wait;
    logic [1:0] r_div_sel;
    logic       r_div_load;
    logic [4:0] r_bit;
    logic [1:0] r_nres;
    logic       r_smooth;
    logic [1:0] r_cnt;
    logic       r_issue;
    logic       r_s1_valid;
    logic [OFS_W-1:0] r_oi;
    logic [OFS_W-1:0] r_oj;

    // payload
    t_coord r_prev_x, r_prev_y, r_mid_x, r_mid_y, r_new_x, r_new_y;
    logic   r_new_last;
    logic signed [DIFF_W-1:0] r_u0, r_v0, r_u2, r_v2, r_du, r_dv;
    t_wide  r_t, r_d, r_n, r_k, r_q3, r_nx, r_ny;
    t_wide  r_rem, r_dsh;
    logic [QBITS-1:0] r_q;
    logic   r_dneg;
    t_coord r_px, r_py, r_cx;
    logic signed [SCAN_W-1:0] r_bx, r_by;
    logic   r_s1_off;
    logic   r_grid_q;
    t_res   r_res0, r_res1, r_fifo0, r_fifo1;

    // grid memory
    logic r_grid [MAP_CELLS];

    // input unpacking
    logic [MAP_AW-1:0] in_index;
    logic signed [7:0] in_value;
    t_coord            in_x, in_y;
    logic              accept, acc_pt, grid_we;

    assign in_index = s_axis_tdata[19:0];
    assign in_value = s_axis_tdata[27:20];
    assign in_x     = s_axis_tdata[51:28];
    assign in_y     = s_axis_tdata[75:52];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign acc_pt   = accept && s_axis_tuser;
    assign grid_we  = accept && !s_axis_tuser;

    // differences around the middle point
    logic signed [DIFF_W-1:0] u0_c, v0_c, u2_c, v2_c;
    logic degen;

    assign u0_c  = DIFF_W'(r_prev_x) - DIFF_W'(r_mid_x);
    assign v0_c  = DIFF_W'(r_prev_y) - DIFF_W'(r_mid_y);
    assign u2_c  = DIFF_W'(in_x) - DIFF_W'(r_mid_x);
    assign v2_c  = DIFF_W'(in_y) - DIFF_W'(r_mid_y);
    assign degen = (u0_c == '0) && (u2_c == '0);

    // window and cell size
    logic [HW_W-1:0]  hx, hy;
    logic [OFS_W-1:0] lim_i, lim_j;
    logic [9:0]       cs_eff;
    logic             chk_on;

    assign hx     = (r_hwx > 7'(MAX_HALF_WINDOW)) ? HW_W'(MAX_HALF_WINDOW) : HW_W'(r_hwx);
    assign hy     = (r_hwy > 7'(MAX_HALF_WINDOW)) ? HW_W'(MAX_HALF_WINDOW) : HW_W'(r_hwy);
    assign lim_i  = OFS_W'({hx, 1'b0}) - OFS_W'(1);
    assign lim_j  = OFS_W'({hy, 1'b0}) - OFS_W'(1);
    assign cs_eff = (r_cell == '0) ? 10'd1 : r_cell;
    assign chk_on = r_map_valid && (hx != '0) && (hy != '0);

    // multiply step operands
    t_wide mul_a, mul_b, mul_c, mul_p;
    logic  mul_sub, mul_start, mul_done;
    logic signed [DIFF_W-1:0] us, vs;

    assign us = r_u0 + r_u2;
    assign vs = r_v0 + r_v2;

    always_comb begin
        mul_a   = t_wide'(r_u0);
        mul_b   = t_wide'(r_u0);
        mul_c   = '0;
        mul_sub = 1'b0;
        unique case (r_op)
            OP_U0U0: begin mul_a = t_wide'(r_u0); mul_b = t_wide'(r_u0); end
            OP_U2U2: begin mul_a = t_wide'(r_u2); mul_b = t_wide'(r_u2); mul_c = r_t; end
            OP_DUDU: begin mul_a = t_wide'(r_du); mul_b = t_wide'(r_du); mul_c = r_t; end
            OP_U0V0: begin mul_a = t_wide'(r_v0); mul_b = t_wide'(r_u0); end
            OP_U2V2: begin mul_a = t_wide'(r_v2); mul_b = t_wide'(r_u2); mul_c = r_t; end
            OP_DUDV: begin mul_a = t_wide'(r_dv); mul_b = t_wide'(r_du); mul_c = r_t; end
            OP_DVS:  begin mul_a = r_d; mul_b = t_wide'(vs); end
            OP_NUS:  begin
                mul_a = r_n; mul_b = t_wide'(us); mul_c = r_t; mul_sub = 1'b1;
            end
            OP_NN:   begin mul_a = r_n; mul_b = r_n; end
            OP_DD:   begin mul_a = r_d; mul_b = r_d; mul_c = r_t; end
            OP_QMX:  begin mul_a = r_q3; mul_b = t_wide'(r_mid_x); end
            OP_NK:   begin mul_a = r_k; mul_b = r_n; mul_c = r_t; mul_sub = 1'b1; end
            OP_QMY:  begin mul_a = r_q3; mul_b = t_wide'(r_mid_y); end
            OP_DK:   begin mul_a = r_k; mul_b = r_d; mul_c = r_t; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_start = (r_state == ST_MUL) && !r_mul_wait;

    wlfs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_c     (mul_c),
        .i_sub   (mul_sub),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // divider: restoring, one quotient bit per cycle, saturating result
    t_wide div_num, div_den;
    logic  div_ge, div_step, div_end;
    logic [QBITS-1:0] q_next, q_sat;
    t_coord div_res;

    always_comb begin
        case (r_div_sel)
            DV_PX:   div_num = r_nx;
            DV_PY:   div_num = r_ny;
            DV_CX:   div_num = t_wide'(r_px);
            default: div_num = t_wide'(r_py);
        endcase
        div_den = r_div_sel[1] ? t_wide'(cs_eff) : r_q3;
    end

    assign div_step = (r_state == ST_DIV) && !r_div_load;
    assign div_end  = div_step && (r_bit == '0);
    assign div_ge   = $unsigned(r_rem) >= $unsigned(r_dsh);
    assign q_next   = {r_q[QBITS-2:0], div_ge};

    always_comb begin
        if (r_dneg) begin
            q_sat = (q_next > NEG_CAP) ? NEG_CAP : q_next;
        end else begin
            q_sat = (q_next > POS_CAP) ? POS_CAP : q_next;
        end
        div_res = t_coord'(r_dneg ? (QBITS'(0) - q_sat) : q_sat);
    end

    // footprint scan address
    logic signed [SCAN_W-1:0] sx, sy;
    logic [21:0] row_ofs;
    logic [22:0] cell_idx;
    logic        cell_off, blocked, scan_clean;

    assign sx       = r_bx + SCAN_W'(r_oi);
    assign sy       = r_by + SCAN_W'(r_oj);
    assign row_ofs  = 22'(sy[10:0]) * 22'(r_map_w);
    assign cell_idx = 23'(sx[10:0]) + 23'(row_ofs);
    assign cell_off = sx[SCAN_W-1] || sy[SCAN_W-1]
                   || ($unsigned(sx) >= SCAN_W'(r_map_w))
                   || ($unsigned(sy) >= SCAN_W'(r_map_h))
                   || (cell_idx >= 23'(MAP_CELLS));
    assign blocked    = (r_state == ST_SCAN) && r_s1_valid && (r_s1_off || r_grid_q);
    assign scan_clean = (r_state == ST_SCAN) && !r_issue && !r_s1_valid;

    // smoothed result selection
    logic   fin_valid;
    logic [1:0] fin_src;
    t_coord fin_x, fin_y, nxt_x, nxt_y;

    always_comb begin
        fin_valid = 1'b0;
        fin_src   = SRC_PROJ;
        fin_x     = r_px;
        fin_y     = r_py;
        if (acc_pt && (r_seen == 2'd2) && degen) begin
            fin_valid = 1'b1;
            fin_src   = SRC_DEGEN;
            fin_x     = r_mid_x;
            fin_y     = r_mid_y;
        end else if (div_end && (r_div_sel == DV_PY) && !chk_on) begin
            fin_valid = 1'b1;
            fin_y     = div_res;
        end else if (blocked) begin
            fin_valid = 1'b1;
            fin_src   = SRC_OBST;
            fin_x     = r_mid_x;
            fin_y     = r_mid_y;
        end else if (scan_clean) begin
            fin_valid = 1'b1;
        end
        nxt_x = (r_state == ST_IDLE) ? in_x : r_new_x;
        nxt_y = (r_state == ST_IDLE) ? in_y : r_new_y;
    end

    // output queue control
    logic emit_go, pop;

    assign emit_go = (r_state == ST_EMIT)
                  && ((r_nres == 2'd2) ? (r_cnt == 2'd0) : (r_cnt != 2'd2));
    assign pop     = m_axis_tvalid && m_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w     <= 11'd1024;
            r_map_h     <= 11'd1024;
            r_cell      <= 10'd50;
            r_hwx       <= 7'd12;
            r_hwy       <= 7'd12;
            r_map_valid <= 1'b0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_MAP_WIDTH:  r_map_w     <= i_cfg_data;
                CFG_MAP_HEIGHT: r_map_h     <= i_cfg_data;
                CFG_CELL_SIZE:  r_cell      <= i_cfg_data[9:0];
                CFG_HALF_X:     r_hwx       <= i_cfg_data[6:0];
                CFG_HALF_Y:     r_hwy       <= i_cfg_data[6:0];
                CFG_MAP_VALID:  r_map_valid <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_seen     <= 2'd0;
            r_op       <= OP_U0U0;
            r_mul_wait <= 1'b0;
            r_div_sel  <= DV_PX;
            r_div_load <= 1'b0;
            r_bit      <= '0;
            r_nres     <= 2'd0;
            r_smooth   <= 1'b0;
            r_cnt      <= 2'd0;
            r_issue    <= 1'b0;
            r_s1_valid <= 1'b0;
            r_oi       <= '0;
            r_oj       <= '0;
        end else begin
            r_cnt <= r_cnt - 2'(pop) + (emit_go ? r_nres : 2'd0);
            unique case (r_state)
                ST_IDLE: begin
                    if (acc_pt) begin
                        case (r_seen)
                            2'd0: begin
                                r_seen   <= s_axis_tlast ? 2'd0 : 2'd1;
                                r_state  <= ST_EMIT;
                                r_nres   <= 2'd1;
                                r_smooth <= 1'b0;
                            end
                            2'd1: begin
                                if (s_axis_tlast) begin
                                    r_seen   <= 2'd0;
                                    r_state  <= ST_EMIT;
                                    r_nres   <= 2'd1;
                                    r_smooth <= 1'b0;
                                end else begin
                                    r_seen <= 2'd2;
                                end
                            end
                            default: begin
                                if (s_axis_tlast) begin
                                    r_seen <= 2'd0;
                                end
                                r_smooth   <= 1'b1;
                                r_nres     <= s_axis_tlast ? 2'd2 : 2'd1;
                                r_op       <= OP_U0U0;
                                r_mul_wait <= 1'b0;
                                r_state    <= degen ? ST_EMIT : ST_MUL;
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    if (!r_mul_wait) begin
                        r_mul_wait <= 1'b1;
                    end else if (mul_done) begin
                        r_mul_wait <= 1'b0;
                        if (r_op == OP_DK) begin
                            r_state    <= ST_DIV;
                            r_div_sel  <= DV_PX;
                            r_div_load <= 1'b1;
                        end else begin
                            r_op <= r_op + 4'd1;
                        end
                    end
                end
                ST_DIV: begin
                    if (r_div_load) begin
                        r_div_load <= 1'b0;
                        r_bit      <= BIT_TOP;
                    end else if (r_bit != '0) begin
                        r_bit <= r_bit - 5'd1;
                    end else begin
                        case (r_div_sel)
                            DV_PX: begin
                                r_div_sel  <= DV_PY;
                                r_div_load <= 1'b1;
                            end
                            DV_PY: begin
                                if (chk_on) begin
                                    r_div_sel  <= DV_CX;
                                    r_div_load <= 1'b1;
                                end else begin
                                    r_state <= ST_EMIT;
                                end
                            end
                            DV_CX: begin
                                r_div_sel  <= DV_CY;
                                r_div_load <= 1'b1;
                            end
                            default: begin
                                r_state    <= ST_SCAN;
                                r_issue    <= 1'b1;
                                r_s1_valid <= 1'b0;
                                r_oi       <= '0;
                                r_oj       <= '0;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    // issue one cell read per cycle, check it the cycle after
                    r_s1_valid <= r_issue;
                    if (r_issue) begin
                        if (r_oj == lim_j) begin
                            r_oj <= '0;
                            if (r_oi == lim_i) begin
                                r_issue <= 1'b0;
                            end else begin
                                r_oi <= r_oi + OFS_W'(1);
                            end
                        end else begin
                            r_oj <= r_oj + OFS_W'(1);
                        end
                    end
                    if (blocked || scan_clean) begin
                        r_issue    <= 1'b0;
                        r_s1_valid <= 1'b0;
                        r_state    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (acc_pt) begin
            r_new_x    <= in_x;
            r_new_y    <= in_y;
            r_new_last <= s_axis_tlast;
            r_u0       <= u0_c;
            r_v0       <= v0_c;
            r_u2       <= u2_c;
            r_v2       <= v2_c;
            r_du       <= u0_c - u2_c;
            r_dv       <= v0_c - v2_c;
            if (r_seen == 2'd0) begin
                r_prev_x <= in_x;
                r_prev_y <= in_y;
            end
            if ((r_seen == 2'd1) && !s_axis_tlast) begin
                r_mid_x <= in_x;
                r_mid_y <= in_y;
            end
            if (r_seen != 2'd2) begin
                r_res0 <= '{x: in_x, y: in_y, src: SRC_ECHO, last: s_axis_tlast};
            end
        end

        // hold the smoothed point and the final echo behind it
        if (fin_valid) begin
            r_res0 <= '{x: fin_x, y: fin_y, src: fin_src, last: 1'b0};
            r_res1 <= '{x: nxt_x, y: nxt_y, src: SRC_ECHO, last: 1'b1};
        end

        // advance the fit window once the smoothed point enters the output queue
        if (emit_go && r_smooth) begin
            r_prev_x <= r_res0.x;
            r_prev_y <= r_res0.y;
            r_mid_x  <= r_new_x;
            r_mid_y  <= r_new_y;
        end

        // store multiply results
        if ((r_state == ST_MUL) && mul_done) begin
            case (r_op)
                OP_DUDU: r_d  <= mul_p;
                OP_DUDV: r_n  <= mul_p;
                OP_NUS:  r_k  <= mul_p;
                OP_DD:   r_q3 <= mul_p + (mul_p <<< 1);
                OP_NK:   r_nx <= mul_p;
                OP_DK:   r_ny <= mul_p;
                default: r_t  <= mul_p;
            endcase
        end

        // divide: load magnitude and shifted divisor, then one bit per cycle
        if ((r_state == ST_DIV) && r_div_load) begin
            r_rem  <= div_num[WIDE_W-1] ? -div_num : div_num;
            r_dneg <= div_num[WIDE_W-1];
            r_dsh  <= div_den << (QBITS - 1);
            r_q    <= '0;
        end else if (div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= q_next;
        end

        if (div_end) begin
            case (r_div_sel)
                DV_PX: r_px <= div_res;
                DV_PY: r_py <= div_res;
                DV_CX: r_cx <= div_res;
                default: begin
                    r_bx <= SCAN_W'(r_cx) - $signed(SCAN_W'(hx));
                    r_by <= SCAN_W'(div_res) - $signed(SCAN_W'(hy));
                end
            endcase
        end

        // off-map flag travels beside the memory read
        r_s1_off <= cell_off;

        // output queue
        if (pop) begin
            r_fifo0 <= r_fifo1;
        end
        if (emit_go) begin
            if ((r_cnt - 2'(pop)) == 2'd0) begin
                r_fifo0 <= r_res0;
                r_fifo1 <= r_res1;
            end else begin
                r_fifo1 <= r_res0;
            end
        end
    end

    // occupancy grid: write on map transfers, read during the scan
    always_ff @(posedge i_clk) begin
        if (grid_we) begin
            r_grid[in_index] <= (in_value >= OCC_LIMIT);
        end
        r_grid_q <= r_grid[cell_idx[MAP_AW-1:0]];
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = {r_fifo0.y, r_fifo0.x};
    assign m_axis_tuser  = r_fifo0.src;
    assign m_axis_tlast  = r_fifo0.last;

`ifndef SYNTHESIS
    a_queue_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue overfilled");

    a_mul_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_MUL) && r_mul_wait)
        else $error("multiplier finished outside a multiply step");

    a_q3_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_step && !r_div_sel[1]) |-> (r_q3 != '0))
        else $error("projection divisor is zero");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && (r_nres == 2'd2)) |-> (r_res1.last && !r_res0.last))
        else $error("result pair out of order");
`endif

endmodule

@@ rtl/wlfs_mul.sv @@
module wlfs_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  wlfs_pkg::t_wide i_a,
    input  wlfs_pkg::t_wide i_b,
    input  wlfs_pkg::t_wide i_c,
    input  logic            i_sub,
    output logic            o_done,
    output wlfs_pkg::t_wide o_p
);
    import wlfs_pkg::*;

    // Shift-add multiply-accumulate: p = c +/- a*b, one bit of b per cycle,
    // finishing as soon as the rest of b is all zeros or all ones.
    t_wide r_a;
    t_wide r_b;
    t_wide r_acc;
    logic  r_busy;
    logic  r_done;
    logic  b_end;

    assign b_end = (r_b == '0) || (r_b == '1);

    // Track busy and flag the finishing cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && b_end) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Load operands, then add one shifted partial product per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_c;
            r_a   <= i_sub ? -i_a : i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b == '1) begin
                r_acc <= r_acc - r_a;
            end else if (r_b != '0) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= r_a <<< 1;
                r_b <= r_b >>> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

@@ sim/waypoint_line_fit_smoother_test.sv @@
`timescale 1ns / 1ps

module waypoint_line_fit_smoother_test;
    import wlfs_pkg::*;

    localparam int        HALF_PERIOD  = 2;
    localparam longint    CYCLE_LIMIT  = 40_000_000;
    localparam int        SETTLE       = 50;
    localparam int        FILL_CELLS   = 4096;
    localparam int        RANDOM_ITEMS = 1000;
    localparam logic [2:0] CFG_UNUSED  = 3'd7;
    localparam logic      MODE_MAP     = 1'b0;
    localparam logic      MODE_POINT   = 1'b1;
    localparam longint    COORD_MAX    = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    localparam longint    COORD_MIN    = -(64'sd1 <<< (COORD_BITS - 1));

    typedef logic signed [299:0] t_exact;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_wen = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [10:0] i_cfg_data = '0;

    waypoint_line_fit_smoother uut (.*);

    // Shadow of the block: grid, path state and registers
    bit     occ_grid [MAP_CELLS];
    longint prev_x, prev_y, mid_x, mid_y;
    int     pts_seen;
    longint map_w = 1024, map_h = 1024, cell_mm = 50, half_x = 12, half_y = 12, map_on = 0;

    t_res   pending_res[$];
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    longint cycle_count = 0;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Randomly stall the result side
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each result transfer with the oldest expected result
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x    = m_axis_tdata[23:0];
            got.y    = m_axis_tdata[47:24];
            got.src  = m_axis_tuser;
            got.last = m_axis_tlast;
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                fail_count++;
            end else begin
                want = pending_res.pop_front();
                if (got.x !== want.x) begin
                    $display("%0t: x expected %0d actual %0d", $time, want.x, got.x);
                    fail_count++;
                end
                if (got.y !== want.y) begin
                    $display("%0t: y expected %0d actual %0d", $time, want.y, got.y);
                    fail_count++;
                end
                if (got.src !== want.src) begin
                    $display("%0t: source expected %0d actual %0d", $time, want.src, got.src);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    function automatic bit cell_blocked(longint cx, longint cy);
        longint idx;
        if (cx < 0 || cx >= map_w || cy < 0 || cy >= map_h) return 1'b1;
        idx = cx + cy * map_w;
        if (idx >= MAP_CELLS) return 1'b1;
        return occ_grid[idx];
    endfunction

    // Scan the footprint window around the cell of a point
    function automatic bit footprint_hit(longint px, longint py);
        longint cs, cx, cy, hx, hy;
        if (map_on == 0) return 1'b0;
        cs = (cell_mm == 0) ? 1 : cell_mm;
        cx = px / cs;
        cy = py / cs;
        hx = (half_x > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : half_x;
        hy = (half_y > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : half_y;
        for (longint i = -hx; i < hx; i++)
            for (longint j = -hy; j < hy; j++)
                if (cell_blocked(cx + i, cy + j)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic longint quot_sat(t_exact num, t_exact den);
        t_exact q;
        q = num / den;
        if (q > t_exact'(COORD_MAX)) return COORD_MAX;
        if (q < t_exact'(COORD_MIN)) return COORD_MIN;
        return longint'(q);
    endfunction

    // Project the held middle point on the least-squares line of three points
    function automatic t_res smooth_mid(longint nx_in, longint ny_in);
        t_exact u0, v0, u2, v2, du, dv, d, n, k, q3, nx, ny;
        t_res   r;
        longint px, py;
        r.x = mid_x; r.y = mid_y; r.last = 1'b0;
        u0 = prev_x - mid_x; v0 = prev_y - mid_y;
        u2 = nx_in - mid_x;  v2 = ny_in - mid_y;
        if (u0 == 0 && u2 == 0) begin
            r.src = SRC_DEGEN;
            return r;
        end
        du = u0 - u2; dv = v0 - v2;
        d  = u0 * u0 + u2 * u2 + du * du;
        n  = u0 * v0 + u2 * v2 + du * dv;
        k  = (v0 + v2) * d - (u0 + u2) * n;
        q3 = 3 * (n * n + d * d);
        nx = t_exact'(mid_x) * q3 - n * k;
        ny = t_exact'(mid_y) * q3 + d * k;
        px = quot_sat(nx, q3);
        py = quot_sat(ny, q3);
        if (footprint_hit(px, py)) begin
            r.src = SRC_OBST;
            return r;
        end
        r.x = px; r.y = py; r.src = SRC_PROJ;
        return r;
    endfunction

    // Advance the shadow state by one accepted item and queue its results
    function automatic void predict_item(logic mode, logic [19:0] idx, logic signed [7:0] val,
                                         logic signed [23:0] px, logic signed [23:0] py,
                                         logic last);
        t_res r;
        if (mode == MODE_MAP) begin
            occ_grid[idx] = (val >= OCC_LIMIT);
            return;
        end
        if (pts_seen == 0) begin
            r.x = px; r.y = py; r.src = SRC_ECHO; r.last = last;
            pending_res.push_back(r);
            prev_x = px; prev_y = py;
            pts_seen = last ? 0 : 1;
        end else if (pts_seen == 1) begin
            if (last) begin
                r.x = px; r.y = py; r.src = SRC_ECHO; r.last = 1'b1;
                pending_res.push_back(r);
                pts_seen = 0;
            end else begin
                mid_x = px; mid_y = py;
                pts_seen = 2;
            end
        end else begin
            r = smooth_mid(px, py);
            pending_res.push_back(r);
            prev_x = r.x; prev_y = r.y;
            mid_x = px; mid_y = py;
            if (last) begin
                r.x = px; r.y = py; r.src = SRC_ECHO; r.last = 1'b1;
                pending_res.push_back(r);
                pts_seen = 0;
            end
        end
    endfunction

    // Present one item, with random gaps ahead, and hold it until the transfer
    task automatic send_item(logic mode, logic [19:0] idx, logic [7:0] val,
                             logic [23:0] px, logic [23:0] py, logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, py, px, val, idx};
        s_axis_tuser  <= mode;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(mode, idx, val, px, py, last);
    endtask

    task automatic send_point(longint px, longint py, logic last);
        send_item(MODE_POINT, $urandom(), $urandom(), px, py, last);
    endtask

    task automatic send_cell(logic [19:0] idx, logic [7:0] val);
        send_item(MODE_MAP, idx, val, $urandom(), $urandom(), $urandom_range(0, 1));
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, longint val);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[10:0];
        @(posedge i_clk);
        case (idx)
            CFG_MAP_WIDTH:  map_w   = val & 11'h7FF;
            CFG_MAP_HEIGHT: map_h   = val & 11'h7FF;
            CFG_CELL_SIZE:  cell_mm = val & 10'h3FF;
            CFG_HALF_X:     half_x  = val & 7'h7F;
            CFG_HALF_Y:     half_y  = val & 7'h7F;
            CFG_MAP_VALID:  map_on  = val & 1;
            default: ;
        endcase
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(longint w, longint h, longint cs, longint hx, longint hy,
                                longint valid);
        drain();
        cfg_write(CFG_MAP_WIDTH, w);
        cfg_write(CFG_MAP_HEIGHT, h);
        cfg_write(CFG_CELL_SIZE, cs);
        cfg_write(CFG_HALF_X, hx);
        cfg_write(CFG_HALF_Y, hy);
        cfg_write(CFG_MAP_VALID, valid);
    endtask

    function automatic logic [7:0] cell_value();
        if ($urandom_range(0, 99) < 8) return $urandom_range(100, 127);
        return 8'($signed($urandom_range(0, 227)) - 128);
    endfunction

    // Write the low cells so that every readable cell holds a known value
    task test_map_fill;
        send_cell(20'hFFFFF, 8'h7F);
        send_cell(20'h00000, 8'h80);
        send_cell(20'h00001, 8'd100);
        send_cell(20'h00002, 8'd99);
        for (int i = 0; i < FILL_CELLS; i++) send_cell(i, cell_value());
        drain();
    endtask

    // Endpoint cases, degenerate fits, obstacles at the map edge, saturation
    task test_directed;
        set_geometry(64, 64, 10, 2, 2, 1);
        send_point(300, 300, 1'b1);
        send_point(100, 100, 1'b0);
        send_point(200, 250, 1'b1);
        send_point(100, 100, 1'b0);
        send_point(200, 220, 1'b0);
        send_point(300, 290, 1'b0);
        send_point(300, 400, 1'b0);
        send_point(300, 500, 1'b1);
        send_point(5, 5, 1'b0);
        send_point(15, 30, 1'b0);
        send_point(600, 10, 1'b1);
        // pause until the block is empty, then aim at the far corners
        set_geometry(64, 64, 10, 0, 0, 1);
        send_point(COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b1);
        set_geometry(0, 1024, 0, 1, 1, 1);
        cfg_write(CFG_UNUSED, 11'h7FF);
        send_point(0, 0, 1'b0);
        send_point(-7, 3, 1'b0);
        send_point(9, -4, 1'b1);
        set_geometry(1, 1024, 1000, 127, 1, 1);
        send_point(100, 5000, 1'b0);
        send_point(400, 9000, 1'b0);
        send_point(-300, 12000, 1'b1);
        set_geometry(1024, 4, 1, 64, 2, 1);
        send_point(100, 1, 1'b0);
        send_point(200, 2, 1'b0);
        send_point(300, 1, 1'b1);
        drain();
    endtask

    function automatic longint jitter(longint base, longint span);
        longint v;
        v = base + $signed($urandom_range(0, 2 * span)) - span;
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return v;
    endfunction

    // Pick a new register setting that keeps every readable cell inside the filled area
    task automatic random_setting;
        longint w, h, cs, hx, hy;
        w  = ($urandom_range(0, 9) == 0) ? 1024 : $urandom_range(1, 64);
        h  = 4096 / w;
        h  = (h > 1024) ? 1024 : h;
        h  = $urandom_range(1, h);
        cs = ($urandom_range(0, 9) == 0) ? 1000 : $urandom_range(1, 40);
        hx = ($urandom_range(0, 19) == 0) ? 12 : $urandom_range(0, 3);
        hy = ($urandom_range(0, 19) == 0) ? 12 : $urandom_range(0, 3);
        set_geometry(w, h, cs, hx, hy, $urandom_range(0, 3) != 0);
    endtask

    // Mostly paths over the map with small steps, some map edits and wild paths
    task automatic test_random(int items, int send_pct, int recv_pct);
        int     done = 0;
        int     len;
        longint x, y, span;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        while (done < items) begin
            if ($urandom_range(0, 5) == 0) random_setting();
            len = $urandom_range(1, 8);
            span = ($urandom_range(0, 9) == 0) ? 8388607 : map_w * cell_mm / 4 + 2;
            x = jitter(map_w * cell_mm / 2, map_w * cell_mm / 2);
            y = jitter(map_h * cell_mm / 2, map_h * cell_mm / 2);
            for (int p = 0; p < len; p++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_cell(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4095),
                              cell_value());
                    done++;
                end
                if ($urandom_range(0, 7) != 0) x = jitter(x, span);
                y = jitter(y, span);
                send_point(x, y, p == len - 1);
                done++;
            end
        end
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_map_fill();
        test_directed();
        test_random(RANDOM_ITEMS / 3, 18, 72);
        test_random(RANDOM_ITEMS / 3, 72, 18);
        test_random(RANDOM_ITEMS / 3, 0, 0);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
